FILE: rtl/kps_pkg.sv
// ---------------------------------------------------------------------------
// Keyword posterior smoother package
// Shared widths, register indexes and the frame result type.
// ---------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

  localparam int SCORE_W    = 8;
  localparam int TIME_W     = 32;
  localparam int SUM_W      = 14;
  localparam int LEN_W      = 7;
  localparam int THR_W      = 8;
  localparam int CNT_W      = 4;
  localparam int TOP_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = LEN_W + THR_W;

  localparam logic [SUM_W-1:0]  SUM_MAX       = '1;
  localparam logic [LEN_W-1:0]  LEN_RESET     = 7'd16;
  localparam logic [THR_W-1:0]  THR_RESET     = 8'd200;
  localparam logic [TIME_W-1:0] SUPP_RESET    = 32'd1000;
  localparam logic [CNT_W-1:0]  CNT_RESET     = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIST_LEN  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_SUPPRESS  = 2'd2,
    CFG_CAT_COUNT = 2'd3
  } cfg_idx_e;

  // Summary of one finished frame, handed from the accumulator to the detector.
  typedef struct packed {
    logic [SUM_W-1:0]  peak_sum;
    logic [TIME_W-1:0] time_ms;
  } frame_t;

endpackage

`default_nettype wire

FILE: rtl/kps_in_if.sv
// ---------------------------------------------------------------------------
// Score channel
// Valid/ready channel carrying one category score and the frame time.
// ---------------------------------------------------------------------------
`default_nettype none

interface kps_in_if;
  logic                         valid;
  logic                         ready;
  logic [kps_pkg::SCORE_W-1:0]  score;
  logic [kps_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, output score, output time_ms, input ready);
  modport sink   (input valid, input score, input time_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/kps_out_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one detection result per frame.
// ---------------------------------------------------------------------------
`default_nettype none

interface kps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         detected;
  logic [kps_pkg::TOP_W-1:0]    top_category;
  logic [kps_pkg::SUM_W-1:0]    peak_sum;

  modport source (output valid, output detected, output top_category, output peak_sum,
                  input ready);
  modport sink   (input valid, input detected, input top_category, input peak_sum,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/kps_hist_mem.sv
// ---------------------------------------------------------------------------
// Score history memory
// Read-first single-port RAM with a clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module kps_hist_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        acc_i,
  input  wire logic [AW-1:0]               addr_i,
  input  wire logic [kps_pkg::SCORE_W-1:0] wdata_i,
  output logic      [kps_pkg::SCORE_W-1:0] rdata_o,
  output logic                             busy_o
);

  logic [kps_pkg::SCORE_W-1:0] mem [DEPTH];
  logic [kps_pkg::SCORE_W-1:0] rdata_q;
  logic [AW-1:0]               clr_addr_q, clr_addr_d;
  logic                        busy_q, busy_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      if (32'(clr_addr_q) == 32'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
    end
  end

  // The old score is read in the same cycle the new one replaces it.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (acc_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

FILE: rtl/kps_accum.sv
// ---------------------------------------------------------------------------
// Moving sum accumulator
// Tracks category and window position, updates per-category sums and the
// running frame maximum, and hands each finished frame to the detector.
// ---------------------------------------------------------------------------
`default_nettype none

module kps_accum #(
  parameter int MAX_CATEGORIES = 8,
  parameter int MAX_HISTORY    = 64,
  parameter int CW             = 3,
  parameter int HW             = 6,
  parameter int AW             = 9
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  kps_in_if.sink                           in_ch,
  input  wire logic [kps_pkg::LEN_W-1:0]   len_i,
  input  wire logic [kps_pkg::CNT_W-1:0]   cnt_i,
  input  wire logic                        busy_i,
  input  wire logic [kps_pkg::SCORE_W-1:0] old_i,
  output logic                             acc_o,
  output logic      [AW-1:0]               addr_o,
  output logic                             fr_valid_o,
  input  wire logic                        fr_ready_i,
  output logic      [CW-1:0]               fr_cat_o,
  output kps_pkg::frame_t                  fr_o
);

  localparam int SUM_W = kps_pkg::SUM_W;

  // Position state, updated at each accepted score.
  logic [CW-1:0] cat_pos_q, cat_pos_d;
  logic [HW-1:0] wp_q, wp_d;

  // Stage 1: the accepted score waits here for its old history value.
  logic                        s1_v_q, s1_v_d;
  logic                        s1_last_q;
  logic [CW-1:0]               s1_cat_q;
  logic [kps_pkg::SCORE_W-1:0] s1_score_q;
  logic [kps_pkg::TIME_W-1:0]  s1_time_q;

  logic [SUM_W-1:0] sums_q [MAX_CATEGORIES];
  logic [SUM_W-1:0] fb_q;
  logic [CW-1:0]    fbc_q;

  logic          last;
  logic [CW-1:0] cat;
  logic [HW-1:0] wp_eff, wp_next;
  logic [31:0]   wp_inc;
  logic          s1_fire, acc;

  logic [SUM_W-1:0] cur_sum, rem_sum, new_sum, best_now;
  logic [SUM_W:0]   add_sum;
  logic [CW-1:0]    cat_now;
  logic             take;

  always_comb begin
    last    = 32'(cat_pos_q) >= (32'(cnt_i) - 32'd1);
    cat     = last ? CW'(cnt_i - 4'd1) : cat_pos_q;
    wp_eff  = (32'(wp_q) >= 32'(len_i)) ? '0 : wp_q;
    wp_inc  = 32'(wp_eff) + 32'd1;
    wp_next = (wp_inc >= 32'(len_i)) ? '0 : HW'(wp_inc);
  end

  assign s1_fire     = s1_v_q && (!s1_last_q || fr_ready_i);
  assign in_ch.ready = !busy_i && (!s1_v_q || s1_fire);
  assign acc         = in_ch.valid && in_ch.ready;
  assign acc_o       = acc;
  assign addr_o      = AW'(32'(cat) * 32'(MAX_HISTORY) + 32'(wp_eff));

  always_comb begin
    cat_pos_d = cat_pos_q;
    wp_d      = wp_q;
    s1_v_d    = s1_v_q;
    if (s1_fire) begin
      s1_v_d = 1'b0;
    end
    if (acc) begin
      s1_v_d    = 1'b1;
      cat_pos_d = last ? '0 : cat + CW'(1);
      wp_d      = last ? wp_next : wp_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cat_pos_q <= '0;
      wp_q      <= '0;
      s1_v_q    <= 1'b0;
    end else begin
      cat_pos_q <= cat_pos_d;
      wp_q      <= wp_d;
      s1_v_q    <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_last_q  <= last;
      s1_cat_q   <= cat;
      s1_score_q <= in_ch.score;
      s1_time_q  <= in_ch.time_ms;
    end
  end

  // Sums can drift from the stored scores after a change of window length,
  // so both the removal and the addition saturate.
  always_comb begin
    cur_sum  = sums_q[s1_cat_q];
    rem_sum  = (cur_sum >= SUM_W'(old_i)) ? cur_sum - SUM_W'(old_i) : '0;
    add_sum  = {1'b0, rem_sum} + (SUM_W + 1)'(s1_score_q);
    new_sum  = (add_sum > {1'b0, kps_pkg::SUM_MAX}) ? kps_pkg::SUM_MAX : add_sum[SUM_W-1:0];
    take     = (s1_cat_q == '0) || (new_sum > fb_q);
    best_now = take ? new_sum : fb_q;
    cat_now  = take ? s1_cat_q : fbc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CATEGORIES; i++) begin
        sums_q[i] <= '0;
      end
      fb_q  <= '0;
      fbc_q <= '0;
    end else if (s1_fire) begin
      sums_q[s1_cat_q] <= new_sum;
      if (s1_last_q) begin
        fb_q  <= '0;
        fbc_q <= '0;
      end else begin
        fb_q  <= best_now;
        fbc_q <= cat_now;
      end
    end
  end

  assign fr_valid_o      = s1_v_q && s1_last_q;
  assign fr_cat_o        = cat_now;
  assign fr_o.peak_sum   = best_now;
  assign fr_o.time_ms    = s1_time_q;

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !in_ch.ready)
    else $error("score transfer accepted during history clearing");

  a_frame_end_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_last_q && !fr_ready_i) |=> (s1_v_q && s1_last_q))
    else $error("stalled frame end was dropped");

endmodule

`default_nettype wire

FILE: rtl/kps_detect.sv
// ---------------------------------------------------------------------------
// Detection stage
// Applies the sum threshold and per-category suppression to each frame and
// holds the result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module kps_detect #(
  parameter int MAX_CATEGORIES = 8,
  parameter int CW             = 3
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fr_valid_i,
  output logic                              fr_ready_o,
  input  wire logic [CW-1:0]                fr_cat_i,
  input  wire kps_pkg::frame_t              fr_i,
  input  wire logic [kps_pkg::LEN_W-1:0]    len_i,
  input  wire logic [kps_pkg::THR_W-1:0]    thr_i,
  input  wire logic [kps_pkg::TIME_W-1:0]   supp_i,
  kps_out_if.source                         out_ch
);

  localparam int LIMIT_W = kps_pkg::LIMIT_W;

  logic                       s2_v_q, s2_v_d;
  logic [CW-1:0]              s2_cat_q;
  kps_pkg::frame_t            s2_q;

  logic [kps_pkg::TIME_W-1:0] ldt_q [MAX_CATEGORIES];
  logic [CW-1:0]              held_q;

  logic                       out_v_q, out_v_d;
  logic                       out_det_q;
  logic [kps_pkg::TOP_W-1:0]  out_top_q;
  logic [kps_pkg::SUM_W-1:0]  out_sum_q;

  logic                       s2_move, det;
  logic [LIMIT_W-1:0]         limit;
  logic [kps_pkg::TIME_W-1:0] gap;
  logic [CW-1:0]              top_next;

  assign s2_move    = s2_v_q && (!out_v_q || out_ch.ready);
  assign fr_ready_o = !s2_v_q || s2_move;

  always_comb begin
    limit    = LIMIT_W'(thr_i) * LIMIT_W'(len_i);
    gap      = s2_q.time_ms - ldt_q[s2_cat_q];
    det      = (LIMIT_W'(s2_q.peak_sum) >= limit) && (gap >= supp_i);
    top_next = det ? s2_cat_q : held_q;
  end

  always_comb begin
    s2_v_d  = s2_v_q;
    out_v_d = out_v_q;
    if (out_v_q && out_ch.ready) begin
      out_v_d = 1'b0;
    end
    if (s2_move) begin
      s2_v_d  = 1'b0;
      out_v_d = 1'b1;
    end
    if (fr_valid_i && fr_ready_o) begin
      s2_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      held_q  <= '0;
      for (int i = 0; i < MAX_CATEGORIES; i++) begin
        ldt_q[i] <= '0;
      end
    end else begin
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
      if (s2_move && det) begin
        ldt_q[s2_cat_q] <= s2_q.time_ms;
        held_q          <= s2_cat_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_valid_i && fr_ready_o) begin
      s2_q     <= fr_i;
      s2_cat_q <= fr_cat_i;
    end
    if (s2_move) begin
      out_det_q <= det;
      out_top_q <= kps_pkg::TOP_W'(top_next);
      out_sum_q <= s2_q.peak_sum;
    end
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.detected     = out_det_q;
  assign out_ch.top_category = out_top_q;
  assign out_ch.peak_sum     = out_sum_q;

  a_time_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_move && det) |=> (ldt_q[$past(s2_cat_q)] == $past(s2_q.time_ms)))
    else $error("detection time not stored for its category");

  a_held_follows_detection: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_move && det) |=> (held_q == $past(s2_cat_q)))
    else $error("held category does not follow the detection");

endmodule

`default_nettype wire

FILE: rtl/keyword_posterior_smoother_unit.sv
// ---------------------------------------------------------------------------
// Keyword posterior smoother
// Per-category moving sums of classifier scores with thresholded,
// suppressed detection of the strongest category once per frame.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one score per transfer, categories in order; the transfer
//   holding the frame's last score also carries the frame time in time_ms.
//   out_ch carries one result per frame: detected, top_category, peak_sum.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
//   writes them only while the block is idle (the block does not enforce it).
// Throughput: one score per cycle when not clearing or stalled, set by
//   the read-first history RAM fetching the leaving score as it stores the new.
// Result path: the RAM read happens at the transfer of a frame's last score,
//   the sum update loads the detection stage register and the detection
//   result loads the output register that drives out_ch.
// Reset: sums, detection times and positions clear at once; the history
//   RAM is then cleared one entry per cycle, MAX_CATEGORIES * MAX_HISTORY
//   entries (512 by default) with in_ch.ready low; register writes still work.
// Stall: a held result keeps one frame in the detection stage; scores keep
//   flowing until the next frame's last score reaches the accumulator, then
//   in_ch.ready drops until out_ch takes the result.
// ---------------------------------------------------------------------------
`default_nettype none

module keyword_posterior_smoother_unit #(
  parameter int MAX_CATEGORIES = 8,
  parameter int MAX_HISTORY    = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [kps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [kps_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  kps_in_if.sink                                in_ch,
  kps_out_if.source                             out_ch
);

  localparam int CW    = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
  localparam int HW    = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int DEPTH = MAX_CATEGORIES * MAX_HISTORY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [kps_pkg::LEN_W-1:0]  len_q, len_eff;
  logic [kps_pkg::THR_W-1:0]  thr_q;
  logic [kps_pkg::TIME_W-1:0] supp_q;
  logic [kps_pkg::CNT_W-1:0]  cnt_q, cnt_eff;

  logic                        acc;
  logic [AW-1:0]               addr;
  logic [kps_pkg::SCORE_W-1:0] old_score;
  logic                        busy;
  logic                        fr_valid, fr_ready;
  logic [CW-1:0]               fr_cat;
  kps_pkg::frame_t             fr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= kps_pkg::LEN_RESET;
      thr_q  <= kps_pkg::THR_RESET;
      supp_q <= kps_pkg::SUPP_RESET;
      cnt_q  <= kps_pkg::CNT_RESET;
    end else if (cfg_we_i) begin
      unique case (kps_pkg::cfg_idx_e'(cfg_idx_i))
        kps_pkg::CFG_HIST_LEN:  len_q  <= cfg_wdata_i[kps_pkg::LEN_W-1:0];
        kps_pkg::CFG_THRESHOLD: thr_q  <= cfg_wdata_i[kps_pkg::THR_W-1:0];
        kps_pkg::CFG_SUPPRESS:  supp_q <= cfg_wdata_i[kps_pkg::TIME_W-1:0];
        kps_pkg::CFG_CAT_COUNT: cnt_q  <= cfg_wdata_i[kps_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; values beyond the storage act as its size.
  always_comb begin
    if (len_q == '0) begin
      len_eff = kps_pkg::LEN_W'(1);
    end else if (32'(len_q) > 32'(MAX_HISTORY)) begin
      len_eff = kps_pkg::LEN_W'(MAX_HISTORY);
    end else begin
      len_eff = len_q;
    end
    if (cnt_q == '0) begin
      cnt_eff = kps_pkg::CNT_W'(1);
    end else if (32'(cnt_q) > 32'(MAX_CATEGORIES)) begin
      cnt_eff = kps_pkg::CNT_W'(MAX_CATEGORIES);
    end else begin
      cnt_eff = cnt_q;
    end
  end

  kps_hist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_hist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .addr_i  (addr),
    .wdata_i (in_ch.score),
    .rdata_o (old_score),
    .busy_o  (busy)
  );

  kps_accum #(
    .MAX_CATEGORIES (MAX_CATEGORIES),
    .MAX_HISTORY    (MAX_HISTORY),
    .CW             (CW),
    .HW             (HW),
    .AW             (AW)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .len_i      (len_eff),
    .cnt_i      (cnt_eff),
    .busy_i     (busy),
    .old_i      (old_score),
    .acc_o      (acc),
    .addr_o     (addr),
    .fr_valid_o (fr_valid),
    .fr_ready_i (fr_ready),
    .fr_cat_o   (fr_cat),
    .fr_o       (fr)
  );

  kps_detect #(
    .MAX_CATEGORIES (MAX_CATEGORIES),
    .CW             (CW)
  ) u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fr_valid_i (fr_valid),
    .fr_ready_o (fr_ready),
    .fr_cat_i   (fr_cat),
    .fr_i       (fr),
    .len_i      (len_eff),
    .thr_i      (thr_q),
    .supp_i     (supp_q),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/sv/kps_smoother_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Posterior smoother checker
// Watches the register port and both channels of the smoother. It keeps its
// own copy of the per-category windows, sums and detection times, works out
// the result of every finished frame and compares it with the result
// transfers in order.
// ---------------------------------------------------------------------------

module kps_smoother_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kps_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  kps_in_if                               in_ch,
  kps_out_if                              out_ch,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_o,
  output int                              detections_o
);
  import kps_pkg::*;

  localparam int NUM_CATS     = 8;
  localparam int WINDOW_DEPTH = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic              detected;
    logic [TOP_W-1:0]  top_category;
    logic [SUM_W-1:0]  peak_sum;
  } frame_result_t;

  logic [LEN_W-1:0]    hist_len;
  logic [THR_W-1:0]    thr_per_frame;
  logic [TIME_W-1:0]   suppress_ms;
  logic [CNT_W-1:0]    cat_count;

  logic [SCORE_W-1:0]  window_scores [NUM_CATS][WINDOW_DEPTH];
  logic [SUM_W-1:0]    cat_sums [NUM_CATS];
  logic [TIME_W-1:0]   last_hit_ms [NUM_CATS];
  int unsigned         cat_pos;
  int unsigned         slot_pos;
  logic [SUM_W-1:0]    frame_best;
  int unsigned         frame_best_cat;
  logic [TOP_W-1:0]    held_cat;

  frame_result_t       expected_frames [$];

  task automatic clear_smoother();
    hist_len      = LEN_RESET;
    thr_per_frame = THR_RESET;
    suppress_ms   = SUPP_RESET;
    cat_count     = CNT_RESET;
    for (int c = 0; c < NUM_CATS; c++) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) window_scores[c][k] = '0;
      cat_sums[c]    = '0;
      last_hit_ms[c] = '0;
    end
    cat_pos        = 0;
    slot_pos       = 0;
    frame_best     = '0;
    frame_best_cat = 0;
    held_cat       = '0;
    expected_frames.delete();
  endtask

  // One score through the moving sums; the frame's last score queues a result.
  task automatic advance_smoother(input logic [SCORE_W-1:0] score,
                                  input logic [TIME_W-1:0] now_ms);
    int unsigned   win_len;
    int unsigned   cats;
    int unsigned   c;
    int unsigned   leaving;
    int unsigned   sum;
    int unsigned   limit;
    logic [TIME_W-1:0] gap;
    logic          closes;
    logic          hit;
    frame_result_t res;
    win_len = (hist_len == 0) ? 1 : ((hist_len > WINDOW_DEPTH) ? WINDOW_DEPTH : hist_len);
    cats    = (cat_count == 0) ? 1 : ((cat_count > NUM_CATS) ? NUM_CATS : cat_count);
    // Register changes without a reset can leave both positions out of range.
    if (slot_pos >= win_len) slot_pos = 0;
    closes = (cat_pos >= cats - 1);
    c      = closes ? cats - 1 : cat_pos;

    leaving = window_scores[c][slot_pos];
    sum     = cat_sums[c];
    sum     = (sum >= leaving) ? sum - leaving : 0;
    sum     = sum + score;
    if (sum > SUM_MAX) sum = SUM_MAX;
    cat_sums[c]               = SUM_W'(sum);
    window_scores[c][slot_pos] = score;

    if (c == 0 || sum > frame_best) begin
      frame_best     = SUM_W'(sum);
      frame_best_cat = c;
    end
    if (!closes) begin
      cat_pos = c + 1;
      return;
    end

    limit = thr_per_frame * win_len;
    gap   = now_ms - last_hit_ms[frame_best_cat];
    hit   = (frame_best >= limit) && (gap >= suppress_ms);
    if (hit) begin
      last_hit_ms[frame_best_cat] = now_ms;
      held_cat = TOP_W'(frame_best_cat);
    end
    res.detected     = hit;
    res.top_category = held_cat;
    res.peak_sum     = frame_best;
    expected_frames.push_back(res);

    cat_pos        = 0;
    frame_best     = '0;
    frame_best_cat = 0;
    slot_pos       = (slot_pos + 1 >= win_len) ? 0 : slot_pos + 1;
  endtask

  task automatic log_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) $display("%t  %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      clear_smoother();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HIST_LEN:  hist_len      = cfg_wdata_i[LEN_W-1:0];
          CFG_THRESHOLD: thr_per_frame = cfg_wdata_i[THR_W-1:0];
          CFG_SUPPRESS:  suppress_ms   = cfg_wdata_i[TIME_W-1:0];
          CFG_CAT_COUNT: cat_count     = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) advance_smoother(in_ch.score, in_ch.time_ms);
      if (out_ch.valid && out_ch.ready) begin
        results_o++;
        if (out_ch.detected) detections_o++;
        if (expected_frames.size() == 0) begin
          log_failure($sformatf("result with no frame pending: det=%0b top=%0d sum=%0d",
                                out_ch.detected, out_ch.top_category, out_ch.peak_sum));
        end else begin
          want = expected_frames.pop_front();
          if (out_ch.detected !== want.detected || out_ch.top_category !== want.top_category
              || out_ch.peak_sum !== want.peak_sum) begin
            log_failure($sformatf({"frame result %0d: expected det=%0b top=%0d sum=%0d, ",
                                   "got det=%0b top=%0d sum=%0d"}, results_o,
                                  want.detected, want.top_category, want.peak_sum,
                                  out_ch.detected, out_ch.top_category, out_ch.peak_sum));
          end
        end
      end
    end
    pending_o = expected_frames.size();
  end

endmodule

FILE: tb/sv/keyword_posterior_smoother_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Posterior smoother testbench
// Drives scores frame by frame under a series of register settings, first a
// handful of directed frames, then random phases with a strong category so
// that detections and suppression occur. Both channels idle at random; the
// checker beside the block predicts and compares every frame result.
// ---------------------------------------------------------------------------

module keyword_posterior_smoother_unit_tb;
  import kps_pkg::*;

  localparam int RANDOM_SCORES = 600;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_HIST_LEN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int results;
  int detections;
  int scores_sent  = 0;
  int settings     = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int rx_left = 0;
  int rx_tick = 0;

  kps_in_if  in_ch ();
  kps_out_if out_ch ();

  keyword_posterior_smoother_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  kps_smoother_checker u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .detections_o (detections)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: each stretch picks its own stall pattern.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(RX_ALWAYS, RX_PERIODIC));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS: out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   out_ch.ready <= ((rx_tick % 5) < 2);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender works in bursts; before each burst a random gap may hold valid low.
  task automatic send_score(input logic [SCORE_W-1:0] score, input logic [TIME_W-1:0] ms);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.score   <= score;
    in_ch.time_ms <= ms;
    do @(posedge clk_i); while (!in_ch.ready);
    scores_sent++;
  endtask

  // Scores are packed with category 0 in the low byte; only the last carries the time.
  task automatic send_frame(input logic [63:0] scores, input int n, input logic [TIME_W-1:0] ms);
    for (int i = 0; i < n; i++) send_score(scores[8*i +: 8], (i == n - 1) ? ms : $urandom());
  endtask

  // Waits until every frame result has been taken and the pipeline is empty.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // All four registers, with junk above the width of the three narrower ones.
  task automatic write_config(input logic [LEN_W-1:0] len, input logic [THR_W-1:0] thr,
                              input logic [TIME_W-1:0] supp, input logic [CNT_W-1:0] cnt);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HIST_LEN;
    cfg_wdata <= {25'($urandom()), len};
    @(negedge clk_i);
    cfg_idx   <= CFG_THRESHOLD;
    cfg_wdata <= {24'($urandom()), thr};
    @(negedge clk_i);
    cfg_idx   <= CFG_SUPPRESS;
    cfg_wdata <= supp;
    @(negedge clk_i);
    cfg_idx   <= CFG_CAT_COUNT;
    cfg_wdata <= {28'($urandom()), cnt};
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [LEN_W-1:0]  len;
    logic [THR_W-1:0]  thr;
    logic [TIME_W-1:0] supp;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] clock_ms;
    int eff_cats;
    int hot_cat;
    int frames;
    int random_sent;
    int tail;

    in_ch.valid   = 1'b0;
    in_ch.score   = '0;
    in_ch.time_ms = '0;
    out_ch.ready  = 1'b0;
    clock_ms      = '0;
    random_sent   = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Window of one: each sum is just the latest score.
    write_config(7'd1, 8'd0, 32'd1000, 4'd4);
    // Threshold of zero, but the time is still inside the first suppression.
    send_frame({8'd0, 8'd0, 8'd0, 8'd0}, 4, 32'd500);
    // Three-way tie: the lowest category wins and detects.
    send_frame({8'd255, 8'd0, 8'd255, 8'd255}, 4, 32'd1000);
    send_frame({8'd40, 8'd30, 8'd200, 8'd10}, 4, 32'd1500);
    // Same category again too soon: suppressed, index held.
    send_frame({8'd0, 8'd0, 8'd255, 8'd0}, 4, 32'd1600);
    drain();
    // Stop in the middle of a wide frame, then shrink the frame under it.
    write_config(7'd64, 8'd255, 32'd0, 4'd8);
    send_frame({24'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 5, 32'd0);
    drain();
    write_config(7'd0, 8'd255, 32'hFFFF_FFFF, 4'd0);
    send_frame(64'd255, 1, 32'hFFFF_FFFF);
    send_frame(64'd0, 1, 32'd0);
    send_frame(64'd128, 1, 32'h8000_0000);
    drain();

    while (random_sent < RANDOM_SCORES) begin
      case ($urandom_range(0, 9))
        0:       len = 7'd0;
        1:       len = 7'd1;
        2:       len = 7'd64;
        3:       len = 7'($urandom_range(65, 127));
        default: len = 7'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        default: thr = 8'($urandom_range(100, 230));
      endcase
      case ($urandom_range(0, 7))
        0:       supp = 32'd0;
        1:       supp = 32'hFFFF_FFFF;
        default: supp = $urandom_range(0, 400);
      endcase
      case ($urandom_range(0, 9))
        0:       cnt = 4'd0;
        1:       cnt = 4'd1;
        2:       cnt = 4'd8;
        3:       cnt = 4'($urandom_range(9, 15));
        default: cnt = 4'($urandom_range(2, 7));
      endcase
      case ($urandom_range(0, 3))
        0: clock_ms = $urandom();
        1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        default: ;
      endcase
      write_config(len, thr, supp, cnt);
      eff_cats = (cnt == 0) ? 1 : ((cnt > 8) ? 8 : cnt);
      hot_cat  = $urandom_range(0, eff_cats - 1);
      frames   = $urandom_range(3, 20);

      // Mostly a steady strong category with random rivals.
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(0, 5) == 0) hot_cat = $urandom_range(0, eff_cats - 1);
        clock_ms += $urandom_range(0, 200);
        for (int c = 0; c < eff_cats; c++) begin
          send_score((c == hot_cat) ? 8'($urandom_range(180, 255)) : 8'($urandom_range(0, 255)),
                     (c == eff_cats - 1) ? clock_ms : $urandom());
          random_sent++;
        end
      end
      // Sometimes leave a frame open across the next register change.
      if (eff_cats > 1 && $urandom_range(0, 3) == 0) begin
        tail = $urandom_range(1, eff_cats - 1);
        for (int i = 0; i < tail; i++) begin
          send_score(8'($urandom_range(0, 255)), $urandom());
          random_sent++;
        end
      end
      drain();
    end

    $display("Sent %0d scores under %0d register settings.", scores_sent, settings);
    $display("Checked %0d frame results, %0d of them detections.", results, detections);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/kps_pkg.sv
rtl/kps_in_if.sv
rtl/kps_out_if.sv
rtl/kps_hist_mem.sv
rtl/kps_accum.sv
rtl/kps_detect.sv
rtl/keyword_posterior_smoother_unit.sv
tb/sv/kps_smoother_checker.sv
tb/sv/keyword_posterior_smoother_unit_tb.sv
